// ----- hw/rtl/ffha_pkg.sv -----
// Package for the first-fit heap allocator: shared constants, types, codes.
// No dependencies.
package ffha_pkg;
  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeaderBytes = 12;
  localparam logic [27:0] HeapMin     = 28'd64;
  localparam logic [27:0] HeapMax     = 28'd134217728;
  localparam logic [31:0] BaseReset   = 32'd1048576;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOOP    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_SLOT, S_SPLIT, S_TAKE, S_FREE, S_NXRD,
    S_MERGE, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init;      // clear table, one free block
    logic latch;     // capture request
    logic rd_cur;    // read entry at cur
    logic adv;       // cur <= link, steps++
    logic slot_scan; // find empty slot (registered)
    logic split;     // write split entries
    logic take;      // mark cur used, add used
    logic free_cur;  // mark cur free, subtract used
    logic rd_nx;     // read entry at link of cur
    logic merge;     // merge cur with next
    logic done;      // result strobe
    status_t st;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic zero_req;
    logic null_addr;
    logic hit;       // cur entry matches
    logic at_end;    // cur is end mark or steps exhausted
    logic can_split;
    logic slot_ok;
    logic nx_free;   // next exists and is free
  } stat_t;
endpackage

// ----- hw/rtl/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator: address-ordered block table with split and merge.
// A no-op request finishes without walking the table; otherwise each entry is read,
// then checked, and a hit goes on through slot scan, split and take, or free and merge.
// One item at a time: start is taken while busy is low.
// Reset (synchronous rst) and any config transfer re-init the table.
// The result is on the ports for one cycle under result_valid; no stall.
module first_fit_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MaxBlocks,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HeaderBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [27:0] req_size,
  input  logic [31:0] address,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [31:0] payload_addr,
  output logic [27:0] used_bytes,
  output logic [27:0] free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  ffha_pkg::cmd_t  ctl;
  ffha_pkg::stat_t st;
  logic cfg_wr;

  // config transfers belong only in idle; the block does not enforce it; always ready
  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid;

  ffha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_wr(cfg_wr),
    .stat(st), .busy(busy), .cmd(ctl)
  );

  ffha_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(ctl), .cfg_wr(cfg_wr), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_cmd(cmd), .in_req_size(req_size),
    .in_address(address), .stat(st), .res_valid(result_valid),
    .res_status(status), .res_payload_addr(payload_addr),
    .res_used_bytes(used_bytes), .res_free_bytes(free_bytes)
  );

  // a result only follows a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without busy");
  // failures never carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ffha_pkg::ST_OK) |-> payload_addr == '0)
    else $error("address on failure");
  // accounting never exceeds the largest heap size
  a_acct: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (29'(used_bytes) + 29'(free_bytes) <= 29'(ffha_pkg::HeapMax)))
    else $error("accounting");
endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
// Controller state machine of the heap allocator.
// Depends on ffha_pkg.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cfg_wr,
  input  ffha_pkg::stat_t stat,
  output logic            busy,
  output ffha_pkg::cmd_t  cmd
);
  ffha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ffha_pkg::S_INIT;
    else if (cfg_wr) state <= ffha_pkg::S_INIT;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    cmd.st = ffha_pkg::ST_OK;
    state_next = state;
    busy = (state != ffha_pkg::S_IDLE);
    unique case (state)
      ffha_pkg::S_INIT: begin
        cmd.init = 1'b1;
        state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_next = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_RD: begin
        if ((stat.is_alloc && stat.zero_req) || (!stat.is_alloc && stat.null_addr)) begin
          cmd.done = 1'b1;
          cmd.st = ffha_pkg::ST_NOOP;
          state_next = ffha_pkg::S_IDLE;
        end else if (stat.at_end) begin
          cmd.done = 1'b1;
          cmd.st = stat.is_alloc ? ffha_pkg::ST_NOMEM : ffha_pkg::ST_UNKNOWN;
          state_next = ffha_pkg::S_IDLE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = ffha_pkg::S_CHK;
        end
      end
      ffha_pkg::S_CHK: begin
        if (stat.hit) begin
          if (!stat.is_alloc) state_next = ffha_pkg::S_FREE;
          else if (stat.can_split) begin
            cmd.slot_scan = 1'b1;
            state_next = ffha_pkg::S_SLOT;
          end else state_next = ffha_pkg::S_TAKE;
        end else begin
          cmd.adv = 1'b1;
          state_next = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_SLOT: state_next = stat.slot_ok ? ffha_pkg::S_SPLIT : ffha_pkg::S_TAKE;
      ffha_pkg::S_SPLIT: begin
        cmd.split = 1'b1;
        state_next = ffha_pkg::S_TAKE;
      end
      ffha_pkg::S_TAKE: begin
        cmd.take = 1'b1;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_FREE: begin
        cmd.free_cur = 1'b1;
        cmd.rd_nx = 1'b1;
        state_next = ffha_pkg::S_NXRD;
      end
      ffha_pkg::S_NXRD: state_next = stat.nx_free ? ffha_pkg::S_MERGE : ffha_pkg::S_DONE;
      ffha_pkg::S_MERGE: begin
        cmd.merge = 1'b1;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        cmd.done = 1'b1;
        state_next = ffha_pkg::S_IDLE;
      end
      default: state_next = ffha_pkg::S_INIT;
    endcase
  end
endmodule

// ----- hw/rtl/ffha_dp.sv -----
// Datapath of the heap allocator: block table memory, slot map, counters.
// Depends on ffha_pkg.
module ffha_dp #(
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MaxBlocks,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HeaderBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  ffha_pkg::cmd_t  cmd,
  input  logic            cfg_wr,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_cmd,
  input  logic [27:0]     in_req_size,
  input  logic [31:0]     in_address,
  output ffha_pkg::stat_t stat,
  output logic            res_valid,
  output logic [1:0]      res_status,
  output logic [31:0]     res_payload_addr,
  output logic [27:0]     res_used_bytes,
  output logic [27:0]     res_free_bytes
);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [LW-1:0] EndMark = LW'(MAX_BLOCKS);
  localparam logic [28:0] Hdr = 29'(HEADER_BYTES);

  logic [31:0] heap_base;
  logic [27:0] heap_bytes;
  logic [27:0] used_total;

  // table memory: offset, size, link; free bits and taken map in flops
  logic [26:0]   mem_off  [MAX_BLOCKS];
  logic [26:0]   mem_size [MAX_BLOCKS];
  logic [LW-1:0] mem_link [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_map, taken_map;

  logic          req_alloc;
  logic [28:0]   need;
  logic [31:0]   req_addr;
  logic [LW-1:0] cur;
  logic [LW:0]   steps;
  logic [26:0]   r_off, r_size;
  logic [LW-1:0] r_link;
  logic          r_free;
  logic [26:0]   n_size;
  logic [LW-1:0] n_link;
  logic [IW-1:0] ns;
  logic          ns_ok;
  logic [27:0]   heap_v;

  always_comb begin
    heap_v = cfg_data[27:0];
    if (heap_v < ffha_pkg::HeapMin) heap_v = ffha_pkg::HeapMin;
    if (heap_v > ffha_pkg::HeapMax) heap_v = ffha_pkg::HeapMax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= ffha_pkg::BaseReset;
      heap_bytes <= ffha_pkg::HeapMax;
    end else if (cfg_wr) begin
      if (!cfg_index) heap_base <= cfg_data;
      else heap_bytes <= heap_v;
    end
  end

  // first empty slot, priority encode registered
  logic [IW-1:0] ns_c;
  logic          ns_ok_c;
  always_comb begin
    ns_c = '0;
    ns_ok_c = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!taken_map[i]) begin
        ns_c = IW'(i);
        ns_ok_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      free_map  <= MAX_BLOCKS'(1);
      taken_map <= MAX_BLOCKS'(1);
      used_total <= '0;
    end else begin
      if (cmd.split) begin
        free_map[ns]  <= 1'b1;
        taken_map[ns] <= 1'b1;
      end
      if (cmd.take) begin
        free_map[cur[IW-1:0]] <= 1'b0;
        used_total <= used_total + 28'(r_size) + 28'(HEADER_BYTES);
      end
      if (cmd.free_cur) begin
        free_map[cur[IW-1:0]] <= 1'b1;
        used_total <= (used_total >= 28'(r_size) + 28'(HEADER_BYTES)) ?
                      used_total - 28'(r_size) - 28'(HEADER_BYTES) : '0;
      end
      if (cmd.merge) begin
        free_map[r_link[IW-1:0]]  <= 1'b0;
        taken_map[r_link[IW-1:0]] <= 1'b0;
      end
    end
  end

  // memory writes (slot 0 rewritten on init); cur entry settled on take
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      mem_off[0]  <= '0;
      mem_size[0] <= 27'(heap_bytes - 28'(HEADER_BYTES));
      mem_link[0] <= EndMark;
    end else if (cmd.split) begin
      mem_off[ns]  <= 27'(29'(r_off) + Hdr + need);
      mem_size[ns] <= 27'(29'(r_size) - need - Hdr);
      mem_link[ns] <= r_link;
    end else if (cmd.take) begin
      mem_size[cur[IW-1:0]] <= r_size;
      mem_link[cur[IW-1:0]] <= r_link;
    end else if (cmd.merge) begin
      mem_size[cur[IW-1:0]] <= r_size + 27'(HEADER_BYTES) + n_size;
      mem_link[cur[IW-1:0]] <= n_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.done;
    end
    if (cmd.latch) begin
      req_alloc <= !in_cmd;
      need <= (29'(in_req_size) + 29'd7) & ~29'd7;
      req_addr <= in_address;
      cur <= '0;
      steps <= '0;
      res_payload_addr <= '0;
    end
    if (cmd.adv) begin
      cur <= r_link;
      steps <= steps + 1'b1;
    end
    if (cmd.rd_cur) begin
      r_off  <= mem_off[cur[IW-1:0]];
      r_size <= mem_size[cur[IW-1:0]];
      r_link <= mem_link[cur[IW-1:0]];
      r_free <= free_map[cur[IW-1:0]];
    end
    if (cmd.slot_scan) begin
      ns <= ns_c;
      ns_ok <= ns_c != '0 && ns_ok_c;
    end
    if (cmd.split) begin
      r_size <= 27'(need);
      r_link <= LW'(ns);
    end
    if (cmd.take) res_payload_addr <= heap_base + 32'(r_off) + 32'(HEADER_BYTES);
    if (cmd.rd_nx) begin
      n_size <= mem_size[r_link[IW-1:0]];
      n_link <= mem_link[r_link[IW-1:0]];
    end
    if (cmd.done) res_status <= cmd.st;
  end

  logic nx_free_c;
  assign nx_free_c = (r_link < EndMark) && free_map[r_link[IW-1:0]];

  assign stat.is_alloc  = req_alloc;
  assign stat.zero_req  = (need == '0);
  assign stat.null_addr = (req_addr == '0);
  assign stat.at_end    = (cur >= EndMark) || (steps >= (LW+1)'(MAX_BLOCKS));
  assign stat.hit       = req_alloc ? (r_free && (29'(r_size) >= need)) :
                          (!r_free && (heap_base + 32'(r_off) + 32'(HEADER_BYTES) == req_addr));
  assign stat.can_split = 29'(r_size) >= need + Hdr + 29'd8;
  assign stat.slot_ok   = ns_ok;
  assign stat.nx_free   = nx_free_c;

  assign res_used_bytes = used_total;
  assign res_free_bytes = (heap_bytes >= used_total) ? heap_bytes - used_total : '0;
endmodule

// ----- verif/first_fit_heap_allocator_top_tb.sv -----
// Self-checking testbench for first_fit_heap_allocator_top: a table-walk predictor
// runs beside the block and every result strobe is compared field by field.
// Depends on ffha_pkg and the first_fit_heap_allocator_top RTL.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_tb;
  localparam int unsigned NB  = ffha_pkg::MaxBlocks;
  localparam int unsigned HDR = ffha_pkg::HeaderBytes;
  localparam bit CMD_ALLOC = 1'b0;
  localparam bit CMD_FREE  = 1'b1;
  localparam bit REG_BASE  = 1'b0;
  localparam bit REG_BYTES = 1'b1;
  localparam int unsigned DRAIN_CYCLES = 2 * NB + 16;

  typedef struct packed {
    ffha_pkg::status_t st;
    logic [31:0]       pay;
    logic [27:0]       used;
    logic [27:0]       free;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = 1'b0;
  logic [27:0] req_size = '0;
  logic [31:0] address = '0;
  logic        result_valid;
  logic [1:0]  status;
  logic [31:0] payload_addr;
  logic [27:0] used_bytes;
  logic [27:0] free_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  first_fit_heap_allocator_top uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the block table, configuration and usage counter.
  // ---------------------------------------------------------------------------
  logic [31:0] m_base;
  logic [27:0] m_heap;
  logic [31:0] m_off  [NB];
  logic [31:0] m_size [NB];
  bit          m_free [NB];
  int unsigned m_link [NB];
  bit          m_taken[NB];
  logic [27:0] m_used;

  // payload addresses of blocks currently handed out, used to aim releases
  logic [31:0] live_addrs[$];
  alloc_result_t expected_q[$];
  int unsigned fail_count = 0;

  function automatic void table_clear();
    for (int i = 0; i < NB; i++) begin
      m_off[i] = 0; m_size[i] = 0; m_free[i] = 0; m_link[i] = NB; m_taken[i] = 0;
    end
    m_size[0]  = {4'd0, m_heap} - HDR;
    m_free[0]  = 1;
    m_taken[0] = 1;
    m_used     = '0;
  endfunction

  function automatic logic [31:0] payload_at(int unsigned s);
    return m_base + m_off[s] + HDR;
  endfunction

  function automatic ffha_pkg::status_t predict_alloc(logic [27:0] req,
                                                      output logic [31:0] pay);
    longint unsigned need;
    int unsigned cur, steps, ns;
    pay = '0;
    if (req == 0) return ffha_pkg::ST_NOOP;
    need = (longint'(req) + 7) & ~64'd7;
    cur = 0; steps = 0;
    while (cur < NB && steps < NB) begin
      if (m_free[cur] && longint'(m_size[cur]) >= need) break;
      cur = m_link[cur];
      steps++;
    end
    if (cur >= NB || steps >= NB) return ffha_pkg::ST_NOMEM;
    if (longint'(m_size[cur]) >= need + HDR + 8) begin
      ns = NB;
      for (int i = NB - 1; i >= 0; i--) if (!m_taken[i]) ns = i;
      // table full: the whole block goes out unsplit
      if (ns < NB) begin
        m_off[ns]   = m_off[cur] + HDR + need[31:0];
        m_size[ns]  = m_size[cur] - need[31:0] - HDR;
        m_free[ns]  = 1;
        m_link[ns]  = m_link[cur];
        m_taken[ns] = 1;
        m_size[cur] = need[31:0];
        m_link[cur] = ns;
      end
    end
    m_free[cur] = 0;
    m_used = 28'(m_used + m_size[cur][27:0] + HDR);
    pay = payload_at(cur);
    return ffha_pkg::ST_OK;
  endfunction

  function automatic ffha_pkg::status_t predict_release(logic [31:0] addr);
    int unsigned cur, steps, nx;
    logic [31:0] amount;
    if (addr == 0) return ffha_pkg::ST_NOOP;
    cur = 0; steps = 0;
    while (cur < NB && steps < NB) begin
      if (!m_free[cur] && payload_at(cur) == addr) break;
      cur = m_link[cur];
      steps++;
    end
    if (cur >= NB || steps >= NB) return ffha_pkg::ST_UNKNOWN;
    m_free[cur] = 1;
    amount = m_size[cur] + HDR;
    m_used = ({4'd0, m_used} >= amount) ? m_used - amount[27:0] : '0;
    nx = m_link[cur];
    // forward merge with a free neighbor
    if (nx < NB && m_free[nx]) begin
      m_size[cur] += HDR + m_size[nx];
      m_link[cur] = m_link[nx];
      m_taken[nx] = 0;
      m_link[nx]  = NB;
      m_free[nx]  = 0;
    end
    return ffha_pkg::ST_OK;
  endfunction

  function automatic alloc_result_t predict_step(bit c, logic [27:0] req, logic [31:0] addr);
    alloc_result_t r;
    logic [31:0] pay;
    pay = '0;
    if (c == CMD_ALLOC) r.st = predict_alloc(req, pay);
    else r.st = predict_release(addr);
    r.pay  = pay;
    r.used = m_used;
    r.free = (m_heap >= m_used) ? m_heap - m_used : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; transfers happen on the rising one.
  // ---------------------------------------------------------------------------
  task automatic send_request(bit c, logic [27:0] req, logic [31:0] addr);
    alloc_result_t r;
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    // the cycle after a transfer is always busy, so the first wait costs nothing
    repeat (gap + 1) @(negedge clk);
    start    <= 1'b1;
    cmd      <= c;
    req_size <= req;
    address  <= addr;
    do @(posedge clk); while (busy);
    // transfer happened at this edge
    r = predict_step(c, req, addr);
    expected_q.push_back(r);
    if (c == CMD_ALLOC && r.st == ffha_pkg::ST_OK) live_addrs.push_back(r.pay);
    if (c == CMD_FREE && r.st == ffha_pkg::ST_OK)
      foreach (live_addrs[i]) if (live_addrs[i] == addr) begin
        live_addrs.delete(i);
        break;
      end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    // a result may trail its last expectation by the walk latency
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(bit idx, logic [31:0] val);
    logic [27:0] v;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASE) begin
      m_base = val;
    end else begin
      v = val[27:0];
      if (v < ffha_pkg::HeapMin) v = ffha_pkg::HeapMin;
      if (v > ffha_pkg::HeapMax) v = ffha_pkg::HeapMax;
      m_heap = v;
    end
    table_clear();
    live_addrs.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic release_random_live();
    int unsigned k;
    if (live_addrs.size() == 0) begin
      send_request(CMD_FREE, 28'($urandom), $urandom);
    end else begin
      k = $urandom_range(0, live_addrs.size() - 1);
      send_request(CMD_FREE, 28'($urandom), live_addrs[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe pops the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && result_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status=%0d addr=%h", status, payload_addr);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status); fail_count++;
        end
        if (payload_addr !== e.pay) begin
          $error("payload_addr: expected %h, actual %h", e.pay, payload_addr); fail_count++;
        end
        if (used_bytes !== e.used) begin
          $error("used_bytes: expected %0d, actual %0d", e.used, used_bytes); fail_count++;
        end
        if (free_bytes !== e.free) begin
          $error("free_bytes: expected %0d, actual %0d", e.free, free_bytes); fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] a0;
    send_request(CMD_ALLOC, 28'd0, 32'd0);           // zero size
    send_request(CMD_FREE, 28'hFFF_FFFF, 32'd0);     // null release
    send_request(CMD_ALLOC, 28'd1, 32'hFFFF_FFFF);   // rounds to 8
    a0 = live_addrs[0];
    send_request(CMD_ALLOC, 28'd8, 32'd0);
    send_request(CMD_ALLOC, 28'd13, 32'd0);
    send_request(CMD_FREE, 28'd0, a0 + 32'd4);       // unknown address
    send_request(CMD_FREE, 28'd0, a0);
    send_request(CMD_FREE, 28'd0, a0);               // double release
    send_request(CMD_ALLOC, 28'hFFF_FFFF, 32'd0);    // no fit
    send_request(CMD_ALLOC, ffha_pkg::HeapMax, 32'd0); // no fit, largest size
    send_request(CMD_FREE, 28'd0, live_addrs[1]);    // merges forward
    send_request(CMD_FREE, 28'd0, live_addrs[0]);
    // exact fit of the largest free block; the front block never merges backward
    send_request(CMD_ALLOC, ffha_pkg::HeapMax - 28'd32, 32'd0);
    send_request(CMD_FREE, 28'd0, live_addrs[0]);
  endtask

  task automatic test_config_extremes();
    // minimal heap near the top of the address space: payload address wraps
    write_register(REG_BASE, 32'hFFFF_FFF8);
    write_register(REG_BYTES, 32'd3);                // saturates to minimum
    send_request(CMD_ALLOC, 28'd20, 32'd0);
    send_request(CMD_ALLOC, 28'd8, 32'd0);
    send_request(CMD_ALLOC, 28'd8, 32'd0);
    send_request(CMD_FREE, 28'd0, live_addrs[0]);
    send_request(CMD_ALLOC, 28'd53, 32'd0);
    write_register(REG_BYTES, 32'hFFFF_FFFF);        // low 28 bits above max
    write_register(REG_BASE, 32'd0);
    send_request(CMD_ALLOC, 28'd100, 32'd0);
    send_request(CMD_FREE, 28'd0, live_addrs[0]);
  endtask

  task automatic test_table_full();
    // more allocations than slots: tail block handed out whole
    write_register(REG_BYTES, 32'd4096);
    for (int i = 0; i < NB + 4; i++) send_request(CMD_ALLOC, 28'd8, 32'd0);
    while (live_addrs.size() > 0) release_random_live();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) begin
        write_register($urandom_range(0, 1) ? REG_BASE : REG_BYTES,
                       $urandom_range(0, 1) ? $urandom : $urandom_range(64, 8192));
      end
      if (i == n / 2) wait_drained();                // sender pauses until all results are in
      roll = $urandom_range(0, 99);
      if (roll < 45)
        send_request(CMD_ALLOC,
                     $urandom_range(0, 3) == 0 ? 28'($urandom) : 28'($urandom_range(1, 600)),
                     $urandom);
      else if (roll < 88) release_random_live();
      else if (roll < 94) send_request(CMD_FREE, 28'($urandom), $urandom);
      else send_request(1'($urandom_range(0, 1)), '0, $urandom_range(0, 1) ? '0 : $urandom);
    end
  endtask

  initial begin
    m_base = ffha_pkg::BaseReset;
    m_heap = ffha_pkg::HeapMax;
    table_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_table_full();
    write_register(REG_BYTES, 32'd2048);
    test_random(600);
    wait_drained();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("first_fit_heap_allocator_top verification clean");
    end else begin
      $display("first_fit_heap_allocator_top verification failed");
    end
    $finish;
  end

  // Watchdog: ~760 items plus drains, with wide margin.
  initial begin
    #20ms;
    $display("first_fit_heap_allocator_top verification failed");
    $finish;
  end
endmodule
